// ----- rtl/xad_pkg.sv -----
// Shared types, constants and coefficient tables for the frame ADPCM decoder.
package xad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TAP_W    = 10;
  localparam int ACC_W    = 28;
  localparam int OFFSET_W = 6;
  localparam int FRAC_W   = 8;
  localparam int CFG_W    = 24;

  localparam logic [7:0]          RAW_MARK   = 8'hEE;
  localparam logic [OFFSET_W-1:0] CODED_LAST = 6'd14;
  localparam logic [OFFSET_W-1:0] RAW_LAST   = 6'd60;
  localparam logic [OFFSET_W-1:0] SEED_ONE   = 6'd2;
  localparam logic [OFFSET_W-1:0] SEED_TWO   = 6'd4;
  localparam logic [4:0]          SHIFT_BASE = 5'd20;
  localparam logic [7:0]          ROUND_BIAS = 8'h80;
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_start;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic accumulate;
  } mac_ctrl_t;

  function automatic logic signed [TAP_W-1:0] tap_one(input logic [1:0] sel);
    logic signed [TAP_W-1:0] t;
    unique case (sel)
      2'd0: t = 10'sd0;
      2'd1: t = 10'sd240;
      2'd2: t = 10'sd460;
      default: t = 10'sd392;
    endcase
    return t;
  endfunction

  function automatic logic signed [TAP_W-1:0] tap_two(input logic [1:0] sel);
    logic signed [TAP_W-1:0] t;
    unique case (sel)
      2'd0: t = 10'sd0;
      2'd1: t = 10'sd0;
      2'd2: t = -10'sd208;
      default: t = -10'sd220;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/xad_mac.sv -----
// Shared multiply-accumulate unit used for both predictor taps.
module xad_mac (
  input  logic                                     clk,
  input  xad_pkg::mac_ctrl_t                       ctrl,
  input  logic signed [xad_pkg::SAMPLE_W-1:0]      mul_a,
  input  logic signed [xad_pkg::TAP_W-1:0]         mul_b,
  input  logic signed [xad_pkg::ACC_W-1:0]         addend,
  output logic signed [xad_pkg::ACC_W-1:0]         acc
);
  import xad_pkg::*;

  logic signed [SAMPLE_W+TAP_W-1:0] product;
  logic signed [ACC_W-1:0]          product_ext;

  assign product     = mul_a * mul_b;
  assign product_ext = ACC_W'(product);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= addend + product_ext;
    end else if (ctrl.accumulate) begin
      acc <= acc + product_ext;
    end
  end

endmodule

// ----- rtl/xa_adpcm_frame_decoder_top.sv -----
// Top level of the frame ADPCM decoder: byte parser, sequencer and output register.
//
//   channel  signals                       direction  carries
//   in       in_valid, in_stall, in_word   into block one stream byte and start mark
//   out      out_valid, out_stall, out_word out        one PCM sample and last mark
//   cfg      cfg_valid, cfg_ready, cfg_data into block sample count
//
// A header, reseed or raw high byte is handled in its accepting cycle; a raw sample's
// low byte then goes to the output step. Each nibble of a coded data byte passes
// through the shared multiplier (first tap, second tap, saturate, output); the output
// step waits while the output register is held and a sample is still due.
// Synchronous reset clears all but the data registers; no clearing pass is needed.
// The input is stalled while a byte is being worked on, and the output register
// accepts a new word in the cycle its old word is taken.
module xa_adpcm_frame_decoder_top #(
  parameter int COUNT_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  xad_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output xad_pkg::out_word_t          out_word,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [xad_pkg::CFG_W-1:0]   cfg_data
);
  import xad_pkg::*;

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TAP1 = 5'b00010,
    S_TAP2 = 5'b00100,
    S_SAT  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                     state;
  logic [CFG_W-1:0]           count_target;
  logic [OFFSET_W-1:0]        frame_offset;
  logic                       raw_frame;
  logic [1:0]                 coef_select;
  logic [4:0]                 shift_amount;
  logic signed [SAMPLE_W-1:0] history_one;
  logic signed [SAMPLE_W-1:0] history_two;
  logic [7:0]                 held_high_byte;
  logic [COUNT_BITS-1:0]      samples_done;
  logic [7:0]                 cur_byte;
  logic                       low_nibble;
  logic signed [SAMPLE_W-1:0] result;

  logic                       in_accept;
  logic                       out_free;
  logic                       out_load;
  logic [OFFSET_W-1:0]        offset_eff;
  logic [3:0]                 nibble;
  logic signed [ACC_W-1:0]    nib_term;
  logic signed [ACC_W-1:0]    addend;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [TAP_W-1:0]    mul_b;
  logic signed [ACC_W-1:0]    acc;
  mac_ctrl_t                  mac_ctrl;
  logic signed [ACC_W-FRAC_W-1:0] scaled;
  logic signed [SAMPLE_W-1:0] sat_value;
  logic signed [SAMPLE_W-1:0] byte_word;
  logic                       count_full;
  logic                       can_emit;
  logic [COUNT_BITS-1:0]      samples_inc;
  logic                       is_last;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign offset_eff = in_word.stream_start ? '0 : frame_offset;
  assign byte_word  = {held_high_byte, in_word.stream_byte};

  assign nibble   = low_nibble ? cur_byte[3:0] : cur_byte[7:4];
  assign nib_term = ACC_W'($signed(nibble)) <<< shift_amount;
  assign addend   = nib_term + ACC_W'($signed({1'b0, ROUND_BIAS}));

  always_comb begin
    mac_ctrl.load       = (state == S_TAP1);
    mac_ctrl.accumulate = (state == S_TAP2);
    if (state == S_TAP2) begin
      mul_a = history_two;
      mul_b = tap_two(coef_select);
    end else begin
      mul_a = history_one;
      mul_b = tap_one(coef_select);
    end
  end

  xad_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .addend (addend),
    .acc    (acc)
  );

  assign scaled = acc[ACC_W-1:FRAC_W];

  always_comb begin
    priority if (scaled > ($bits(scaled))'(SAT_MAX)) begin
      sat_value = SAT_MAX;
    end else if (scaled < ($bits(scaled))'(SAT_MIN)) begin
      sat_value = SAT_MIN;
    end else begin
      sat_value = scaled[SAMPLE_W-1:0];
    end
  end

  assign count_full  = &samples_done;
  assign can_emit    = !count_full && (CMP_W'(samples_done) < CMP_W'(count_target));
  assign samples_inc = samples_done + COUNT_BITS'(1);
  assign is_last     = (CMP_W'(samples_inc) == CMP_W'(count_target));
  assign out_free    = !out_valid || !out_stall;
  assign out_load    = (state == S_OUT) && can_emit && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_target <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_target <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word.sample      <= result;
      out_word.last_sample <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      frame_offset   <= '0;
      raw_frame      <= 1'b0;
      coef_select    <= '0;
      shift_amount   <= '0;
      history_one    <= '0;
      history_two    <= '0;
      held_high_byte <= '0;
      samples_done   <= '0;
      low_nibble     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            cur_byte   <= in_word.stream_byte;
            low_nibble <= 1'b0;
            if (in_word.stream_start) begin
              history_one  <= '0;
              history_two  <= '0;
              samples_done <= '0;
            end
            if (offset_eff == '0) begin
              frame_offset <= OFFSET_W'(1);
              if (in_word.stream_byte == RAW_MARK) begin
                raw_frame <= 1'b1;
              end else begin
                raw_frame    <= 1'b0;
                coef_select  <= in_word.stream_byte[5:4];
                shift_amount <= SHIFT_BASE - {1'b0, in_word.stream_byte[3:0]};
              end
            end else if (!raw_frame) begin
              frame_offset <= (offset_eff >= CODED_LAST) ? '0 : offset_eff + OFFSET_W'(1);
              state        <= S_TAP1;
            end else begin
              frame_offset <= (offset_eff >= RAW_LAST) ? '0 : offset_eff + OFFSET_W'(1);
              priority if (offset_eff[0]) begin
                held_high_byte <= in_word.stream_byte;
              end else if (offset_eff == SEED_ONE) begin
                history_one <= byte_word;
              end else if (offset_eff == SEED_TWO) begin
                history_two <= byte_word;
              end else begin
                result     <= byte_word;
                low_nibble <= 1'b1;
                state      <= S_OUT;
              end
            end
          end
        end
        S_TAP1: begin
          state <= S_TAP2;
        end
        S_TAP2: begin
          state <= S_SAT;
        end
        S_SAT: begin
          result      <= sat_value;
          history_two <= history_one;
          history_one <= sat_value;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (!can_emit || out_free) begin
            if (out_load) begin
              samples_done <= samples_inc;
            end
            if (low_nibble) begin
              state <= S_IDLE;
            end else begin
              low_nibble <= 1'b1;
              state      <= S_TAP1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    samples_done != $past(samples_done) |->
      samples_done == $past(samples_done) + COUNT_BITS'(1) || samples_done == '0)
    else $error("sample counter moved by more than one");

  a_load_not_full: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !count_full && state == S_OUT)
    else $error("output word loaded with the counter at its limit");

  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && can_emit && out_valid && out_stall |=> state == S_OUT)
    else $error("sequencer left the output step while a sample was blocked");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    state == S_TAP1 |=> state == S_TAP2 && $stable(cur_byte))
    else $error("byte changed during predictor sequence");
`endif

endmodule
